// ===== design/ltm_pkg.sv =====
// shared types, constants and the microcode program of the loop transport block
// depends on nothing; every other design file imports it
`default_nettype none

package ltm_pkg;

  // sample format and loop bound
  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_LOOP_BARS = 64;

  // configuration port
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_INDEX_W = 2;

  // largest loop a Q8.32 position can hold is 64 bars
  localparam logic [6:0] LOOP_CAP = 7'((MAX_LOOP_BARS > 64) ? 64 : MAX_LOOP_BARS);

  // register reset values
  localparam logic [23:0] BEAT_INC_RST = 24'd178957;
  localparam logic [39:0] PERIOD_RST   = 40'd1572864000;
  localparam logic [6:0]  BARS_RST     = 7'd1;

  // fixed point constants
  localparam logic [39:0] ONE_Q16   = 40'd65536;
  localparam logic [23:0] ENV_ONE   = 24'h800000;
  localparam logic [23:0] ENV_MIN   = 24'd8389;
  localparam logic [31:0] DECAY_Q24 = 32'd16760439;
  localparam logic [63:0] DECAY_RND = 64'd8388608;
  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

  // exact reciprocals for 31-bit dividends: ceil(2^k / d)
  localparam logic [31:0] RECIP_42 = 32'd3272356036;  // k = 37
  localparam logic [31:0] RECIP_20 = 32'd3435973837;  // k = 36
  localparam logic [31:0] RECIP_6  = 32'd2863311531;  // k = 34
  localparam int SH_42 = 37;
  localparam int SH_20 = 36;
  localparam int SH_6  = 34;

  // rounding of the Q0.31 click down to the sample format
  localparam int CLICK_SH = 32 - SAMPLE_BITS;
  localparam logic [32:0] CLICK_HALF = (CLICK_SH == 0) ? 33'd0 : (33'd1 << (CLICK_SH - 1));

  // saturation bounds of a widened sample sum
  localparam logic signed [SAMPLE_BITS+1:0] SUM_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS+1:0] SUM_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  // width of the loop count quotient (position >> 34)
  localparam int MOD_BITS = 7;

  // request and result payloads
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          run;
  } src_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [39:0]                   beat_position;
    logic [23:0]                   bar_phase;
    logic                          click_start;
  } res_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BEAT_INC   = 2'd0,
    REG_SPB        = 2'd1,
    REG_LOOP_BARS  = 2'd2,
    REG_METRONOME  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [23:0] beat_increment;
    logic [39:0] beat_period;
    logic [6:0]  loop_bars;
    logic        metronome;
  } cfg_t;

  // datapath operations, one per control word
  typedef enum logic [4:0] {
    OP_WAIT,
    OP_BEAT_ADD,
    OP_MOD_STEP,
    OP_BEAT_WB,
    OP_NOP,
    OP_COUNT,
    OP_X2,
    OP_Q42,
    OP_P1,
    OP_Q20,
    OP_P2,
    OP_Q6,
    OP_S,
    OP_V,
    OP_MIX,
    OP_DECAY,
    OP_OUT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_NOT_RUN,
    C_NO_CLICK,
    C_ENV_LOW,
    C_MOD_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ACCEPT = 5'd0;
  localparam step_t STEP_MOD    = 5'd2;
  localparam step_t STEP_CLICK  = 5'd4;
  localparam step_t STEP_EMIT   = 5'd16;
  localparam step_t PROG_LAST   = STEP_EMIT;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic take;
    logic emit;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic run;
    logic click_on;
    logic env_low;
    logic mod_more;
  } dp_flags_t;

  // microcode program: jump to target when the condition holds, else next step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      5'd0:    w = '{OP_WAIT,     C_NO_REQ,   STEP_ACCEPT};
      5'd1:    w = '{OP_BEAT_ADD, C_NOT_RUN,  STEP_CLICK};
      5'd2:    w = '{OP_MOD_STEP, C_MOD_MORE, STEP_MOD};
      5'd3:    w = '{OP_BEAT_WB,  C_NEVER,    STEP_ACCEPT};
      5'd4:    w = '{OP_NOP,      C_NO_CLICK, STEP_EMIT};
      5'd5:    w = '{OP_COUNT,    C_NEVER,    STEP_ACCEPT};
      5'd6:    w = '{OP_X2,       C_ENV_LOW,  STEP_EMIT};
      5'd7:    w = '{OP_Q42,      C_NEVER,    STEP_ACCEPT};
      5'd8:    w = '{OP_P1,       C_NEVER,    STEP_ACCEPT};
      5'd9:    w = '{OP_Q20,      C_NEVER,    STEP_ACCEPT};
      5'd10:   w = '{OP_P2,       C_NEVER,    STEP_ACCEPT};
      5'd11:   w = '{OP_Q6,       C_NEVER,    STEP_ACCEPT};
      5'd12:   w = '{OP_S,        C_NEVER,    STEP_ACCEPT};
      5'd13:   w = '{OP_V,        C_NEVER,    STEP_ACCEPT};
      5'd14:   w = '{OP_MIX,      C_NEVER,    STEP_ACCEPT};
      5'd15:   w = '{OP_DECAY,    C_NEVER,    STEP_ACCEPT};
      5'd16:   w = '{OP_OUT,      C_OUT_BUSY, STEP_EMIT};
      default: w = '{OP_NOP,      C_ALWAYS,   STEP_ACCEPT};
    endcase
    return w;
  endfunction

  // add a non-negative click to a sample with saturation
  function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
    logic signed [SAMPLE_BITS-1:0] s,
    logic [SAMPLE_BITS:0]          c
  );
    logic signed [SAMPLE_BITS+1:0] w;
    logic signed [SAMPLE_BITS-1:0] r;
    w = $signed({{2{s[SAMPLE_BITS-1]}}, s}) + $signed({1'b0, c});
    if (w > SUM_MAX) begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (w < SUM_MIN) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = w[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/loop_transport_metronome.sv =====
// Loop transport with metronome click, one stereo sample pair per request.
// A request carries left_in, right_in (signed Q1.23) and run. While run is
// high the Q8.32 beat position advances by beat_increment and wraps at
// loop_length_bars * 4 beats; with the metronome on, a click envelope
// restarts every samples_per_beat samples and sin(e/2)*e/2 is added to
// both channels with saturation. The result carries both samples, the
// beat position, the bar phase and a click start flag.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
// The microcode program runs 7 remainder steps for the loop wrap, then 10
// steps for the click series, mix and envelope decay on one shared 32x32
// multiplier. One request is in work at a time, so a new request is taken
// only after the result of the last one has been emitted.
// The result sits in an output register; while res_stall is high it holds,
// and the sequencer waits at its output step, so no new request is taken.
// Synchronous reset clears the position, the click counter, the envelope
// and the registers to their defaults; no request is lost across a stall.
// Depends on ltm_pkg, ltm_cfg, ltm_seq and ltm_dp.
`default_nettype none

module loop_transport_metronome import ltm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   src_valid,
  output logic                   src_stall,
  input  src_t                   src_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output res_t                   res_data
);

  cfg_t      cfg;
  ctl_t      ctl;
  dp_flags_t flags;
  res_t      res;
  logic      out_busy;

  assign out_busy  = res_valid && res_stall;
  assign src_stall = rst || (ctl.op != OP_WAIT);

  ltm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ltm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .out_busy  (out_busy),
    .flags     (flags),
    .ctl       (ctl)
  );

  ltm_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .src   (src_data),
    .cfg   (cfg),
    .flags (flags),
    .res   (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/ltm_cfg.sv =====
// configuration registers of the loop transport block
// depends on ltm_pkg for register indexes, reset values and the cfg_t struct
`default_nettype none

module ltm_cfg import ltm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [6:0]  bars_wr;
  logic [6:0]  bars_clamped;
  logic [39:0] period_clamped;

  // loop length clamps to one .. loop cap
  assign bars_wr = cfg_data[6:0];
  always_comb begin
    if (bars_wr == 7'd0) begin
      bars_clamped = 7'd1;
    end else if (bars_wr > LOOP_CAP) begin
      bars_clamped = LOOP_CAP;
    end else begin
      bars_clamped = bars_wr;
    end
  end

  // click period below one sample counts as one sample
  assign period_clamped = (cfg_data[39:0] < ONE_Q16) ? ONE_Q16 : cfg_data[39:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beat_increment <= BEAT_INC_RST;
      cfg.beat_period    <= PERIOD_RST;
      cfg.loop_bars      <= BARS_RST;
      cfg.metronome      <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BEAT_INC:  cfg.beat_increment <= cfg_data[23:0];
        REG_SPB:       cfg.beat_period    <= period_clamped;
        REG_LOOP_BARS: cfg.loop_bars      <= bars_clamped;
        REG_METRONOME: cfg.metronome      <= cfg_data[0];
        default:       cfg.metronome      <= cfg.metronome;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ltm_seq.sv =====
// microcode sequencer: step counter, program table lookup and conditional jumps
// depends on ltm_pkg for the program, control word and flag types
`default_nettype none

module ltm_seq import ltm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      out_busy,
  input  dp_flags_t flags,
  output ctl_t      ctl
);

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   jump;

  // control word of the current step
  assign word = ucode_rom(step);

  // jump condition
  always_comb begin
    case (word.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_REQ:   jump = !src_valid;
      C_NOT_RUN:  jump = !flags.run;
      C_NO_CLICK: jump = !flags.click_on;
      C_ENV_LOW:  jump = flags.env_low;
      C_MOD_MORE: jump = flags.mod_more;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (jump) begin
      step_next = word.target;
    end else if (step == PROG_LAST) begin
      step_next = STEP_ACCEPT;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  // control outputs
  always_comb begin
    ctl.op   = word.op;
    ctl.take = (word.op == OP_WAIT) && src_valid;
    ctl.emit = (word.op == OP_OUT) && !out_busy;
  end

endmodule

`default_nettype wire

// ===== design/ltm_dp.sv =====
// datapath: beat position, loop wrap remainder, click counter, envelope and
// click series on one shared 32x32 multiplier; depends on ltm_pkg
`default_nettype none

module ltm_dp import ltm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctl_t      ctl,
  input  src_t      src,
  input  cfg_t      cfg,
  output dp_flags_t flags,
  output res_t      res
);

  // sample and loop state
  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] right;
  logic                          run;
  logic [39:0]                   acc;
  logic [40:0]                   sum;
  logic [5:0]                    rem;
  logic [2:0]                    mbit;
  logic [39:0]                   cnt;
  logic [23:0]                   env;
  logic                          start;

  // series registers
  logic [30:0] x2;
  logic [31:0] t;
  logic [30:0] p;
  logic [30:0] x;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // remainder step
  logic [MOD_BITS-1:0] quo;
  logic [6:0]          rem_sh;
  logic [6:0]          rem_sub;
  logic [5:0]          rem_new;

  // click counter
  logic [40:0] cnt_inc;
  logic [40:0] cnt_wrap;
  logic        hit;

  // click rounding and decay
  logic [32:0]            vh;
  logic [SAMPLE_BITS:0]   click;
  logic [63:0]            decay_sum;

  assign x = {env, 7'b0};

  // multiplier operands
  always_comb begin
    case (ctl.op)
      OP_X2:    begin mul_a = {1'b0, x};    mul_b = {1'b0, x};  end
      OP_Q42:   begin mul_a = {1'b0, x2};   mul_b = RECIP_42;   end
      OP_P1:    begin mul_a = {1'b0, x2};   mul_b = t;          end
      OP_Q20:   begin mul_a = {1'b0, p};    mul_b = RECIP_20;   end
      OP_P2:    begin mul_a = {1'b0, x2};   mul_b = t;          end
      OP_Q6:    begin mul_a = {1'b0, p};    mul_b = RECIP_6;    end
      OP_S:     begin mul_a = {1'b0, x};    mul_b = t;          end
      OP_V:     begin mul_a = {1'b0, p};    mul_b = {1'b0, x};  end
      OP_DECAY: begin mul_a = {8'b0, env};  mul_b = DECAY_Q24;  end
      default:  begin mul_a = 32'd0;        mul_b = 32'd0;      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // one restoring bit of (position >> 34) mod bars
  assign quo     = sum[40:34];
  assign rem_sh  = {rem, quo[mbit]};
  assign rem_sub = rem_sh - cfg.loop_bars;
  assign rem_new = (rem_sh >= cfg.loop_bars) ? rem_sub[5:0] : rem_sh[5:0];

  // click counter advance and wrap
  assign cnt_inc  = {1'b0, cnt} + {1'b0, ONE_Q16};
  assign hit      = cnt_inc >= {1'b0, cfg.beat_period};
  assign cnt_wrap = cnt_inc - {1'b0, cfg.beat_period};

  // click in sample format, rounded half up
  assign vh    = {2'b0, p} + CLICK_HALF;
  assign click = vh[CLICK_SH +: SAMPLE_BITS+1];

  assign decay_sum = prod + DECAY_RND;

  // state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 40'd0;
      cnt   <= 40'd0;
      env   <= 24'd0;
      start <= 1'b0;
      run   <= 1'b0;
    end else begin
      case (ctl.op)
        OP_WAIT: begin
          if (ctl.take) begin
            run   <= src.run;
            start <= 1'b0;
          end
        end
        OP_BEAT_WB: acc <= {rem, sum[33:0]};
        OP_COUNT: begin
          if (hit) begin
            cnt   <= cnt_wrap[39:0];
            env   <= ENV_ONE;
            start <= 1'b1;
          end else begin
            cnt   <= cnt_inc[39:0];
          end
        end
        OP_DECAY: env <= decay_sum[47:24];
        default:  env <= env;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_WAIT: begin
        if (ctl.take) begin
          left  <= src.left_in;
          right <= src.right_in;
        end
      end
      OP_BEAT_ADD: begin
        sum  <= {1'b0, acc} + {17'b0, cfg.beat_increment};
        rem  <= 6'd0;
        mbit <= 3'(MOD_BITS - 1);
      end
      OP_MOD_STEP: begin
        rem  <= rem_new;
        mbit <= mbit - 3'd1;
      end
      OP_X2:  x2 <= prod[61:31];
      OP_Q42: t  <= ONE_Q31 - 32'(prod >> SH_42);
      OP_P1:  p  <= prod[61:31];
      OP_Q20: t  <= ONE_Q31 - 32'(prod >> SH_20);
      OP_P2:  p  <= prod[61:31];
      OP_Q6:  t  <= ONE_Q31 - 32'(prod >> SH_6);
      OP_S:   p  <= prod[61:31];
      OP_V:   p  <= prod[61:31];
      OP_MIX: begin
        left  <= sat_add(left, click);
        right <= sat_add(right, click);
      end
      default: p <= p;
    endcase
  end

  // flags for the sequencer
  assign flags.run      = run;
  assign flags.click_on = run && cfg.metronome;
  assign flags.env_low  = env < ENV_MIN;
  assign flags.mod_more = mbit != 3'd0;

  // result fields
  assign res.left_out      = left;
  assign res.right_out     = right;
  assign res.beat_position = acc;
  assign res.bar_phase     = acc[33:10];
  assign res.click_start   = start;

endmodule

`default_nettype wire

// ===== tb/sv/loop_transport_metronome_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for loop_transport_metronome: directed and random sample requests
// checked against an in-bench transport and click predictor; depends on ltm_pkg and the block

module loop_transport_metronome_test;
  import ltm_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam int HALF_PERIOD  = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int ACCUM_PHASES = 9;
  localparam int ACCUM_ITEMS  = 125;
  localparam int WRAP_ITEMS   = 60;
  localparam int MIX_PHASES   = 3;
  localparam int MIX_ITEMS    = 40;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint  PEAK  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;

  localparam logic [6:0]  BAR_CAP    = (MAX_LOOP_BARS > 64) ? 7'd64 : 7'(MAX_LOOP_BARS);
  localparam logic [63:0] ONE_SAMPLE = 64'd65536;
  localparam logic [63:0] MASK_40    = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] MASK_24    = 64'hFF_FFFF;
  localparam logic [63:0] ENV_FULL   = 64'h80_0000;
  localparam logic [63:0] ENV_FLOOR  = 64'd8389;
  localparam logic [63:0] DECAY      = 64'd16760439;
  localparam logic [63:0] HALF_Q24   = 64'd8388608;
  localparam logic [63:0] UNIT_Q31   = 64'h8000_0000;
  localparam int          CLICK_DROP = 32 - SAMPLE_BITS;
  localparam logic [63:0] CLICK_RND  = (64'd1 << CLICK_DROP) >> 1;

  // block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  reg_index_t            cfg_index = REG_BEAT_INC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  src_valid = 1'b0;
  logic                  src_stall;
  src_t                  src_data = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res_data;

  // predictor copy of registers and state
  logic [23:0] set_inc;
  logic [39:0] set_period;
  logic [6:0]  set_bars;
  logic        set_click;
  logic [63:0] beat_pos;
  logic [63:0] click_cnt;
  logic [63:0] env_level;

  src_t pending_samples[$];
  res_t due_results[$];

  // pacing and bookkeeping
  int src_gap_max = 0;
  int res_wait_max = 0;
  int src_gap = 0;
  int res_wait = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet = 0;
  bit src_taken = 1'b0;
  bit res_taken = 1'b0;
  int faults = 0;
  int n_samples = 0;
  int n_stopped = 0;
  int n_clicks = 0;
  int n_settings = 0;

  loop_transport_metronome u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // saturate a widened sum back to the sample format
  function automatic sample_t clamp_sample(longint v);
    if (v > PEAK) begin
      return S_MAX;
    end else if (v < -PEAK - 1) begin
      return S_MIN;
    end
    return sample_t'(v);
  endfunction

  // one sample pair through the transport, click counter and mixer
  function automatic res_t advance_transport(src_t s);
    res_t        r;
    logic [63:0] span;
    logic [63:0] period;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sn;
    logic [63:0] v;
    logic [63:0] click;
    longint      lsum;
    longint      rsum;
    logic        start;
    lsum  = longint'(s.left_in);
    rsum  = longint'(s.right_in);
    start = 1'b0;
    // beat position wraps at bars * 4 beats, Q8.32
    if (s.run) begin
      span     = {57'd0, set_bars} << 34;
      beat_pos = (beat_pos + {40'd0, set_inc}) % span;
    end
    // click counter, envelope restart and mix
    if (s.run && set_click) begin
      period    = (set_period < ONE_SAMPLE) ? ONE_SAMPLE : {24'd0, set_period};
      click_cnt = click_cnt + ONE_SAMPLE;
      if (click_cnt >= period) begin
        click_cnt = click_cnt - period;
        env_level = ENV_FULL;
        start     = 1'b1;
      end
      click_cnt = click_cnt & MASK_40;
      if (env_level >= ENV_FLOOR) begin
        // sin(x) * x by truncated series, x = envelope / 2 in Q0.31
        x     = env_level << 7;
        x2    = (x * x) >> 31;
        t     = UNIT_Q31 - x2 / 42;
        t     = UNIT_Q31 - ((x2 * t) >> 31) / 20;
        t     = UNIT_Q31 - ((x2 * t) >> 31) / 6;
        sn    = (x * t) >> 31;
        v     = (sn * x) >> 31;
        click = (v + CLICK_RND) >> CLICK_DROP;
        lsum  = lsum + longint'(click);
        rsum  = rsum + longint'(click);
        env_level = ((env_level * DECAY + HALF_Q24) >> 24) & MASK_24;
      end
    end
    r.left_out      = clamp_sample(lsum);
    r.right_out     = clamp_sample(rsum);
    r.beat_position = beat_pos[39:0];
    r.bar_phase     = beat_pos[33:10];
    r.click_start   = start;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  function automatic void queue_sample(sample_t l, sample_t r, logic run);
    src_t s;
    s.left_in  = l;
    s.right_in = r;
    s.run      = run;
    pending_samples.push_back(s);
  endfunction

  // extremes now and then, otherwise full-range noise
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // click period: under one sample, huge, any, or a few dozen samples
  function automatic logic [39:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return 40'($urandom_range(0, 65535));
      1:       return 40'hFF_FFFF_FFFF;
      2:       return {8'($urandom), 32'($urandom)};
      default: return 40'($urandom_range(1, 40)) * 40'd65536 + 40'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 15;
    endcase
  endfunction

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // all four registers, unused upper data bits filled with noise
  task automatic configure(logic [23:0] inc, logic [39:0] period, logic [6:0] bars,
                           logic metro);
    logic [6:0] b;
    b = bars;
    if (b < 7'd1) b = 7'd1;
    if (b > BAR_CAP) b = BAR_CAP;
    set_inc    = inc;
    set_period = period;
    set_bars   = b;
    set_click  = metro;
    put_reg(REG_BEAT_INC, {16'($urandom), inc});
    put_reg(REG_SPB, period);
    put_reg(REG_LOOP_BARS, {33'($urandom), bars});
    put_reg(REG_METRONOME, {39'($urandom), metro});
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || due_results.size() != 0) @(negedge clk);
  endtask

  // request side: take at the rising edge, predict right away
  always @(posedge clk) begin
    if (!rst && src_valid && !src_stall) begin
      due_results.push_back(advance_transport(src_data));
      void'(pending_samples.pop_front());
      src_taken = 1'b1;
      n_samples++;
      if (!src_data.run) n_stopped++;
    end
  end

  // request driver: random gap before each request, payload held while stalled
  always @(negedge clk) begin
    if (!rst && (src_taken || !src_valid)) begin
      if (src_taken) begin
        src_taken = 1'b0;
        src_gap   = $urandom_range(0, src_gap_max);
      end
      if (src_gap != 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        src_valid <= 1'b1;
        src_data  <= pending_samples[0];
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // result checker against the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      res_taken = 1'b1;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: %h", res_data);
        faults++;
      end else begin
        want = due_results.pop_front();
        check_field("left_out", want.left_out, res_data.left_out);
        check_field("right_out", want.right_out, res_data.right_out);
        check_field("beat_position", want.beat_position, res_data.beat_position);
        check_field("bar_phase", want.bar_phase, res_data.bar_phase);
        check_field("click_start", want.click_start, res_data.click_start);
        if (want.click_start) n_clicks++;
      end
    end
  end

  // result stall: random wait per result, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst) begin
      if (res_taken) begin
        res_taken = 1'b0;
        res_wait  = $urandom_range(0, res_wait_max);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (res_wait != 0) begin
        res_wait--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int k;
    logic [23:0] inc;

    set_inc    = 24'd178957;
    set_period = 40'd1572864000;
    set_bars   = 7'd1;
    set_click  = 1'b0;
    beat_pos   = '0;
    click_cnt  = '0;
    env_level  = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset values, stopped and running extremes
    queue_sample(S_MAX, S_MIN, 1'b0);
    queue_sample(S_MIN, S_MAX, 1'b1);
    queue_sample('0, '1, 1'b1);
    drain();

    // metronome on, no click due yet: silent envelope; zero bars clamp to one
    configure(24'hFF_FFFF, 40'hFF_FFFF_FFFF, 7'd0, 1'b1);
    queue_sample(sample_t'(1), sample_t'(1), 1'b1);
    queue_sample(S_MAX, S_MIN, 1'b1);
    drain();

    // period under one sample clicks every sample; zero increment; bars saturate
    configure(24'd0, 40'd100, 7'd127, 1'b1);
    queue_sample(S_MAX, S_MAX, 1'b1);
    queue_sample(S_MIN, S_MIN, 1'b1);
    queue_sample(pick_sample(), pick_sample(), 1'b1);
    queue_sample(pick_sample(), pick_sample(), 1'b1);
    queue_sample(S_MAX, '0, 1'b0);
    drain();

    // long period lets the counter build up
    configure(24'hFF_FFFF, 40'd688128, 7'd64, 1'b1);
    for (k = 0; k < 6; k++) queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    // period dropped below the counter: back-to-back clicks
    configure(24'hFF_FFFF, 40'd131072, 7'd64, 1'b1);
    for (k = 0; k < 6; k++) queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    // metronome off: counter and envelope hold, samples pass
    configure(24'hFF_FFFF, 40'd131072, 7'd64, 1'b0);
    queue_sample(S_MAX, S_MIN, 1'b1);
    queue_sample(pick_sample(), pick_sample(), 1'b1);
    drain();

    // mostly running at top speed so the position climbs past one bar
    for (ph = 0; ph < ACCUM_PHASES; ph++) begin
      configure(24'hFF_FFFF, pick_period(),
                (ph == 4) ? 7'd127 : ((ph == 6) ? 7'd64 : 7'($urandom_range(2, 63))),
                $urandom_range(0, 3) != 0);
      src_gap_max  = pick_pace();
      res_wait_max = pick_pace();
      if (ph == 2) hold_req = HOLD_CYCLES;
      for (k = 0; k < ACCUM_ITEMS; k++) begin
        queue_sample(pick_sample(), pick_sample(), $urandom_range(0, 31) != 0);
      end
      drain();
    end

    // loop cut to one bar with the position beyond it: hold while stopped, then wrap
    configure(24'hFF_FFFF, pick_period(), 7'($urandom_range(0, 1)), 1'b1);
    src_gap_max  = 15;
    res_wait_max = 15;
    for (k = 0; k < 4; k++) queue_sample(pick_sample(), pick_sample(), 1'b0);
    for (k = 4; k < WRAP_ITEMS; k++) begin
      queue_sample(pick_sample(), pick_sample(), $urandom_range(0, 7) != 0);
    end
    drain();

    // fully random settings
    for (ph = 0; ph < MIX_PHASES; ph++) begin
      inc = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom);
      configure(inc, pick_period(), 7'($urandom_range(0, 127)), $urandom_range(0, 1) != 0);
      src_gap_max  = pick_pace();
      res_wait_max = pick_pace();
      for (k = 0; k < MIX_ITEMS; k++) begin
        queue_sample(pick_sample(), pick_sample(), $urandom_range(0, 3) != 0);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d sample requests (%0d stopped) over %0d register settings,",
             n_samples, n_stopped, n_settings);
    $display("with %0d click restarts and %0d failures", n_clicks, faults);
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
